>>> sv/lge_pkg.sv
// shared types, constants and codes for the life generation engine
`default_nettype none

package lge_pkg;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 32;

	localparam int ROW_W   = 5;
	localparam int COL_W   = 5;
	localparam int SIZE_W  = 6;
	localparam int COUNT_W = 11;
	localparam int PCNT_W  = $clog2(MAX_COLS + 1);
	localparam int NBR_W   = 4;

	localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(32);
	localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(32);

	localparam logic [NBR_W-1:0] SURVIVE_LOW  = NBR_W'(2);
	localparam logic [NBR_W-1:0] SURVIVE_HIGH = NBR_W'(3);
	localparam logic [NBR_W-1:0] BIRTH_COUNT  = NBR_W'(3);

	// configuration register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef logic [MAX_COLS-1:0] row_word_t;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_READ    = 2'd1,
		REQ_ADVANCE = 2'd2,
		REQ_NOP     = 2'd3
	} req_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_ADV_R0,
		ST_ADV_R1,
		ST_ADV_R2,
		ST_ADV_CALC,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_CNT_RD,
		ST_CNT_ACC,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> sv/lge_row_rule.sv
// life rule for one whole grid row, one lane per column, with toroidal column wrap
`default_nettype none

module lge_row_rule import lge_pkg::*; (
	input  row_word_t        above,
	input  row_word_t        mid,
	input  row_word_t        below,
	input  logic [COL_W-1:0] nc_m1,
	output row_word_t        next_row
);

	logic a_w, m_w, b_w;

	// cells of the last active column, seen by column zero
	assign a_w = above[nc_m1];
	assign m_w = mid[nc_m1];
	assign b_w = below[nc_m1];

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
		logic [2:0]       lft;
		logic [2:0]       rgt;
		logic [NBR_W-1:0] nbr;

		if (c == 0) begin : g_lft_wrap
			assign lft = {a_w, m_w, b_w};
		end else begin : g_lft
			assign lft = {above[c-1], mid[c-1], below[c-1]};
		end

		if (c == MAX_COLS - 1) begin : g_rgt_wrap
			assign rgt = {above[0], mid[0], below[0]};
		end else begin : g_rgt
			assign rgt = (COL_W'(c) == nc_m1) ? {above[0], mid[0], below[0]}
			                                  : {above[c+1], mid[c+1], below[c+1]};
		end

		// own cell left out: with tiny sizes the wrapped copies still count
		assign nbr = NBR_W'($countones({lft, rgt, above[c], below[c]}));

		assign next_row[c] = mid[c] ? ((nbr >= SURVIVE_LOW) && (nbr <= SURVIVE_HIGH))
		                            : (nbr == BIRTH_COUNT);
	end

endmodule

`default_nettype wire

>>> sv/life_generation_engine.sv
// top level: toroidal game of life grid with cell write, cell read and generation step
//
// requests come in on start/busy: a word is taken at a clock edge with start high and
// busy low (req_type, row_index, col_index, cell_value). every request gives exactly
// one result word: done is high for one cycle with read_value and live_count valid,
// and the receiver must take it then; there is no back-pressure on the result side.
// the grid is stored one row per memory word, so the sequencer works a row at a time
// through a single memory read port and one row-wide rule unit.
// a write or the unused kind goes straight to the live count sweep (read each active
// row, then add its live cells); a read first fetches the addressed row and latches
// the cell, then sweeps. an advance fetches the row above, the row itself and the row
// below for each active row and writes the rule result to scratch memory, then copies
// the scratch rows back, then sweeps; done follows the last row of the sweep.
// one request at a time: busy stays high through done, and the next word can be taken
// in the cycle after done, so a new word is not taken while one is in progress. the
// row and column sizes (rows_cfg_q, cols_cfg_q) are written on cfg_we/cfg_index/cfg_data;
// the user must write them only while idle; the block itself does not enforce it. reset
// clears the grid through per-row valid bits (no clearing pass) and sets both sizes to 32.
`default_nettype none

module life_generation_engine import lge_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [SIZE_W-1:0]  cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [ROW_W-1:0]   row_index,
	input  logic [COL_W-1:0]   col_index,
	input  logic               cell_value,
	output logic               done,
	output logic               read_value,
	output logic [COUNT_W-1:0] live_count
);

	state_t state_q, state_d;

	logic [SIZE_W-1:0]  rows_cfg_q, cols_cfg_q;
	logic [SIZE_W-1:0]  nr, nc, nr_m1, nc_m1;
	logic [ROW_W-1:0]   r_q;
	logic [ROW_W-1:0]   row_up, row_dn;
	logic               row_last;
	logic [COL_W-1:0]   col_q;
	logic               in_region, in_region_q;
	logic               rd_q;
	logic [COUNT_W-1:0] count_q;
	row_word_t          win0_q, win1_q;
	row_word_t          col_mask, bit_sel, next_row;

	// grid memory and scratch memory
	row_word_t          cell_grid [MAX_ROWS];
	row_word_t          next_grid [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_valid_q;
	row_word_t          cg_rdata_q, cg_rd, ng_rdata_q;
	logic               cg_rvalid_q;
	logic               cg_re, cg_we, ng_we, ng_re;
	logic [ROW_W-1:0]   cg_raddr, cg_waddr;
	row_word_t          cg_wdata, cg_wmask, cg_wmask_eff;

	// active sizes: zero acts as one, oversize saturates
	assign nr = (rows_cfg_q == '0) ? SIZE_W'(1) :
	            (rows_cfg_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_cfg_q;
	assign nc = (cols_cfg_q == '0) ? SIZE_W'(1) :
	            (cols_cfg_q > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_cfg_q;
	assign nr_m1 = nr - SIZE_W'(1);
	assign nc_m1 = nc - SIZE_W'(1);

	assign row_last = ({1'b0, r_q} == nr_m1);
	assign row_up   = (r_q == '0) ? nr_m1[ROW_W-1:0] : r_q - ROW_W'(1);
	assign row_dn   = row_last ? '0 : r_q + ROW_W'(1);

	assign in_region = ({1'b0, row_index} < nr) && ({1'b0, col_index} < nc);

	always_comb begin
		for (int i = 0; i < MAX_COLS; i++) begin
			col_mask[i] = (SIZE_W'(i) < nc);
		end
	end

	assign bit_sel = row_word_t'(1) << col_index;

	// rows never written since reset read as dead
	assign cg_rd = cg_rvalid_q ? cg_rdata_q : '0;

	lge_row_rule u_rule (
		.above    (win0_q),
		.mid      (win1_q),
		.below    (cg_rd),
		.nc_m1    (nc_m1[COL_W-1:0]),
		.next_row (next_row)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= ROWS_RESET;
			cols_cfg_q <= COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_cfg_q <= cfg_data;
				REG_COLS: cols_cfg_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// sequencer next state and memory controls
	always_comb begin
		state_d  = state_q;
		cg_re    = 1'b0;
		cg_raddr = r_q;
		cg_we    = 1'b0;
		cg_waddr = r_q;
		cg_wdata = ng_rdata_q & col_mask;
		cg_wmask = col_mask;
		ng_we    = 1'b0;
		ng_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_kind_t'(req_type))
						REQ_WRITE: begin
							cg_we    = in_region;
							cg_waddr = row_index;
							cg_wdata = cell_value ? bit_sel : '0;
							cg_wmask = bit_sel;
							state_d  = ST_CNT_RD;
						end
						REQ_READ: begin
							cg_re    = 1'b1;
							cg_raddr = row_index;
							state_d  = ST_READ;
						end
						REQ_ADVANCE: state_d = ST_ADV_R0;
						REQ_NOP:     state_d = ST_CNT_RD;
						default:     state_d = ST_CNT_RD;
					endcase
				end
			end
			ST_READ: state_d = ST_CNT_RD;
			ST_ADV_R0: begin
				cg_re    = 1'b1;
				cg_raddr = row_up;
				state_d  = ST_ADV_R1;
			end
			ST_ADV_R1: begin
				cg_re    = 1'b1;
				cg_raddr = r_q;
				state_d  = ST_ADV_R2;
			end
			ST_ADV_R2: begin
				cg_re    = 1'b1;
				cg_raddr = row_dn;
				state_d  = ST_ADV_CALC;
			end
			ST_ADV_CALC: begin
				ng_we   = 1'b1;
				state_d = row_last ? ST_COPY_RD : ST_ADV_R0;
			end
			ST_COPY_RD: begin
				ng_re   = 1'b1;
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				cg_we   = 1'b1;
				state_d = row_last ? ST_CNT_RD : ST_COPY_RD;
			end
			ST_CNT_RD: begin
				cg_re   = 1'b1;
				state_d = ST_CNT_ACC;
			end
			ST_CNT_ACC: state_d = row_last ? ST_DONE : ST_CNT_RD;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// a row never written takes a full-word write, outside bits already zero
	assign cg_wmask_eff = row_valid_q[cg_waddr] ? cg_wmask : '1;

	always_ff @(posedge clk) begin
		if (cg_we) begin
			for (int i = 0; i < MAX_COLS; i++) begin
				if (cg_wmask_eff[i]) begin
					cell_grid[cg_waddr][i] <= cg_wdata[i];
				end
			end
		end
		if (cg_re) begin
			cg_rdata_q <= cell_grid[cg_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			cg_rvalid_q <= 1'b0;
		end else begin
			if (cg_we) begin
				row_valid_q[cg_waddr] <= 1'b1;
			end
			if (cg_re) begin
				cg_rvalid_q <= row_valid_q[cg_raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ng_we) begin
			next_grid[r_q] <= next_row;
		end
		if (ng_re) begin
			ng_rdata_q <= next_grid[r_q];
		end
	end

	// sequencer state and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			count_q <= '0;
			rd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						r_q     <= '0;
						count_q <= '0;
						rd_q    <= 1'b0;
					end
				end
				ST_READ: rd_q <= in_region_q & cg_rd[col_q];
				ST_ADV_CALC, ST_COPY_WR: r_q <= row_last ? '0 : r_q + ROW_W'(1);
				ST_CNT_ACC: begin
					count_q <= count_q + COUNT_W'(PCNT_W'($countones(cg_rd & col_mask)));
					r_q     <= row_last ? '0 : r_q + ROW_W'(1);
				end
				default: ;
			endcase
		end
	end

	// request payload and row window
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			col_q       <= col_index;
			in_region_q <= in_region;
		end
		if (state_q == ST_ADV_R1) begin
			win0_q <= cg_rd;
		end
		if (state_q == ST_ADV_R2) begin
			win1_q <= cg_rd;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = (state_q == ST_DONE);
	assign read_value = rd_q;
	assign live_count = count_q;

endmodule

`default_nettype wire

>>> tb/life_generation_engine_checker.sv
// checker for the life generation engine: predicts every result word and compares it

module life_generation_engine_checker import lge_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [SIZE_W-1:0]  cfg_data,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         req_type,
	input  logic [ROW_W-1:0]   row_index,
	input  logic [COL_W-1:0]   col_index,
	input  logic               cell_value,
	input  logic               done,
	input  logic               read_value,
	input  logic [COUNT_W-1:0] live_count,
	output int                 words_pending,
	output int                 mismatches
);

	typedef struct packed {
		logic               rd;
		logic [COUNT_W-1:0] count;
	} grid_result_t;

	row_word_t          life_grid [MAX_ROWS];
	logic [SIZE_W-1:0]  rows_reg;
	logic [SIZE_W-1:0]  cols_reg;
	grid_result_t       expected_words [$];

	function automatic int span_of(logic [SIZE_W-1:0] raw, int lim);
		if (raw == '0)
			return 1;
		if (int'(raw) > lim)
			return lim;
		return int'(raw);
	endfunction

	function automatic logic [COUNT_W-1:0] count_live(int nr, int nc);
		int n;
		n = 0;
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				n += life_grid[r][c];
		return (n > 2047) ? COUNT_W'(2047) : COUNT_W'(n);
	endfunction

	// whole active region from the old grid, then copy back; outside cells stay put
	function automatic void step_generation(int nr, int nc);
		row_word_t nxt [MAX_ROWS];
		int        rs [3];
		int        cs [3];
		int        sum;
		logic      self;
		for (int r = 0; r < nr; r++) begin
			rs[0] = (r == 0) ? nr - 1 : r - 1;
			rs[1] = r;
			rs[2] = (r + 1 == nr) ? 0 : r + 1;
			for (int c = 0; c < nc; c++) begin
				cs[0] = (c == 0) ? nc - 1 : c - 1;
				cs[1] = c;
				cs[2] = (c + 1 == nc) ? 0 : c + 1;
				self = life_grid[r][c];
				// on tiny grids several offsets land on one cell, each one counts
				sum = 0;
				for (int a = 0; a < 3; a++)
					for (int b = 0; b < 3; b++)
						sum += life_grid[rs[a]][cs[b]];
				sum -= self;
				if (self)
					nxt[r][c] = (sum >= SURVIVE_LOW && sum <= SURVIVE_HIGH);
				else
					nxt[r][c] = (sum == BIRTH_COUNT);
			end
		end
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				life_grid[r][c] = nxt[r][c];
	endfunction

	function automatic grid_result_t apply_request(req_kind_t kind, logic [ROW_W-1:0] r,
			logic [COL_W-1:0] c, logic v);
		int           nr;
		int           nc;
		logic         inside_region;
		grid_result_t res;
		nr = span_of(rows_reg, MAX_ROWS);
		nc = span_of(cols_reg, MAX_COLS);
		inside_region = (int'(r) < nr) && (int'(c) < nc);
		res.rd = 1'b0;
		case (kind)
			REQ_WRITE: begin
				if (inside_region)
					life_grid[r][c] = v;
			end
			REQ_READ: begin
				if (inside_region)
					res.rd = life_grid[r][c];
			end
			REQ_ADVANCE: step_generation(nr, nc);
			REQ_NOP: ;
			default: ;
		endcase
		res.count = count_live(nr, nc);
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t life checker: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		grid_result_t got;
		grid_result_t want;
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++)
				life_grid[r] = '0;
			rows_reg = ROWS_RESET;
			cols_reg = COLS_RESET;
			expected_words.delete();
			mismatches = 0;
			words_pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROWS)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			if (start && !busy)
				expected_words.push_back(apply_request(req_kind_t'(req_type), row_index,
					col_index, cell_value));
			if (done) begin
				got.rd = read_value;
				got.count = live_count;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("result word with nothing expected (rd %b count %0d)",
						got.rd, got.count));
				end else begin
					want = expected_words.pop_front();
					if (got.rd !== want.rd)
						report_mismatch($sformatf("read_value %b, expected %b", got.rd, want.rd));
					if (got.count !== want.count)
						report_mismatch($sformatf("live_count %0d, expected %0d",
							got.count, want.count));
				end
			end
			words_pending <= expected_words.size();
		end
	end

endmodule

>>> tb/life_generation_engine_tb.sv
// testbench top for the life generation engine: clock, reset, request stimulus and verdict

module life_generation_engine_tb import lge_pkg::*; ();

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES      = 13;
	localparam int PHASE_ITEMS = 44;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = REG_ROWS;
	logic [SIZE_W-1:0]  cfg_data = '0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         req_type = REQ_NOP;
	logic [ROW_W-1:0]   row_index = '0;
	logic [COL_W-1:0]   col_index = '0;
	logic               cell_value = 1'b0;
	logic               done;
	logic               read_value;
	logic [COUNT_W-1:0] live_count;

	int words_pending;
	int mismatches;
	int cycle_count = 0;

	int idle_pct = 0;
	int cur_rows = MAX_ROWS;
	int cur_cols = MAX_COLS;
	int win_r = 0;
	int win_c = 0;
	int sent_writes = 0;
	int sent_reads = 0;
	int sent_steps = 0;
	int sent_nops = 0;
	int settings_used = 0;

	int phase_rows [PHASES] = '{32, 1, 2, 3, 0, 63, 6, 32, 4, 1, 5, 2, 0};
	int phase_cols [PHASES] = '{32, 1, 3, 2, 5, 63, 6, 1, 32, 0, 5, 2, 0};

	life_generation_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.row_index  (row_index),
		.col_index  (col_index),
		.cell_value (cell_value),
		.done       (done),
		.read_value (read_value),
		.live_count (live_count)
	);

	life_generation_engine_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.row_index     (row_index),
		.col_index     (col_index),
		.cell_value    (cell_value),
		.done          (done),
		.read_value    (read_value),
		.live_count    (live_count),
		.words_pending (words_pending),
		.mismatches    (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d words pending",
				cycle_count, words_pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// start stays high across back-to-back words; anything else lowers it first
	task automatic send_word(req_kind_t kind, int r, int c, logic v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= kind;
		row_index  <= ROW_W'(r);
		col_index  <= COL_W'(c);
		cell_value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		case (kind)
			REQ_WRITE:   sent_writes++;
			REQ_READ:    sent_reads++;
			REQ_ADVANCE: sent_steps++;
			REQ_NOP:     sent_nops++;
			default:     ;
		endcase
	endtask

	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (words_pending != 0 || busy !== 1'b0);
	endtask

	task automatic set_sizes(int rr, int cc);
		drain;
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROWS;
		cfg_data  <= SIZE_W'(rr);
		@(posedge clk);
		cfg_index <= REG_COLS;
		cfg_data  <= SIZE_W'(cc);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_rows = (rr == 0) ? 1 : ((rr > MAX_ROWS) ? MAX_ROWS : rr);
		cur_cols = (cc == 0) ? 1 : ((cc > MAX_COLS) ? MAX_COLS : cc);
		settings_used++;
	endtask

	// mostly a small window that wraps the torus edges, some words anywhere in the store
	task automatic random_word;
		int pick;
		int r;
		int c;
		pick = $urandom_range(99);
		r = ($urandom_range(99) < 15) ? $urandom_range(31)
		                              : (win_r + $urandom_range(5)) % cur_rows;
		c = ($urandom_range(99) < 15) ? $urandom_range(31)
		                              : (win_c + $urandom_range(5)) % cur_cols;
		if (pick < 45)
			send_word(REQ_WRITE, r, c, $urandom_range(99) < 60);
		else if (pick < 65)
			send_word(REQ_READ, r, c, 1'($urandom_range(1)));
		else if (pick < 93)
			send_word(REQ_ADVANCE, r, c, 1'($urandom_range(1)));
		else
			send_word(REQ_NOP, r, c, 1'($urandom_range(1)));
		if ($urandom_range(29) == 0)
			drain;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blinker across the column and row wrap at the reset size
		send_word(REQ_WRITE, 0, 31, 1'b1);
		send_word(REQ_WRITE, 0, 0, 1'b1);
		send_word(REQ_WRITE, 0, 1, 1'b1);
		send_word(REQ_READ, 0, 0, 1'b0);
		send_word(REQ_ADVANCE, 0, 0, 1'b0);
		send_word(REQ_READ, 31, 0, 1'b0);
		send_word(REQ_READ, 1, 0, 1'b0);
		send_word(REQ_READ, 0, 31, 1'b0);
		send_word(REQ_ADVANCE, 31, 31, 1'b1);
		send_word(REQ_READ, 0, 31, 1'b0);
		send_word(REQ_WRITE, 31, 31, 1'b1);
		send_word(REQ_READ, 31, 31, 1'b1);
		send_word(REQ_NOP, 31, 31, 1'b1);
		send_word(REQ_WRITE, 31, 31, 1'b0);
		send_word(REQ_READ, 31, 31, 1'b0);
		send_word(REQ_ADVANCE, 0, 0, 1'b0);
		send_word(REQ_READ, 31, 0, 1'b0);
		send_word(REQ_READ, 0, 0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1)
				set_sizes($urandom_range(63), $urandom_range(63));
			else
				set_sizes(phase_rows[p], phase_cols[p]);
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 53;
				default: idle_pct = 17;
			endcase
			win_r = $urandom_range(cur_rows - 1);
			win_c = $urandom_range(cur_cols - 1);
			repeat (PHASE_ITEMS)
				random_word;
		end

		drain;
		repeat (300) @(posedge clk);
		$display("covered %0d request words: %0d writes, %0d reads, %0d generation steps,",
			sent_writes + sent_reads + sent_steps + sent_nops, sent_writes, sent_reads,
			sent_steps);
		$display("%0d unused kind, over %0d grid size settings from 1x1 to full, %s",
			sent_nops, settings_used, "zero and oversize values included");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
